FILE: design/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and codes for the circular byte FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;

    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONSUME   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RST_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RST_WRITE = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_CONSUME,
        OP_RST_RD,
        OP_RST_WR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] wbyte;
        logic [LEN_W-1:0]  length;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } state_t;

endpackage

FILE: design/byte_ring_fifo_top.sv
// Order: a result beat is registered in the output register as its command leaves the
//   queue; the first byte of a read passes through the store's registered read first.
// Write, consume, pointer resets and empty reads each give one result beat; a read of
//   n bytes starts the store read, then sends one beat per byte, fetching ahead.
// A two-entry command queue lets input beats arrive while results are stalled.
// Reset empties the FIFO and sets capacity to DEPTH; the byte store is not cleared.
// ----------------------------------------------------------------------------
// byte_ring_fifo_top
// Circular byte FIFO with write, burst read, consume and pointer reset commands.
// ----------------------------------------------------------------------------
module byte_ring_fifo_top #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [brf_pkg::LEN_W-1:0] cfg_wdata,  // capacity
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,    // write_byte[7:0], length[18:8]
    input  logic [brf_pkg::CMD_W-1:0] s_tuser,    // command[2:0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,    // read_byte[7:0], count[18:8],
                                                  // occupancy[29:19]
    output logic                      m_tuser,    // byte_valid
    output logic                      m_tlast
);

    import brf_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    brf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    brf_back #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: design/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/brf_front.sv
// ----------------------------------------------------------------------------
// brf_front
// Command intake: decodes each beat and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module brf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,
    input  logic [brf_pkg::CMD_W-1:0]    s_tuser,
    output logic                         cmd_valid,
    output brf_pkg::cmd_t                cmd,
    input  logic                         cmd_pop
);

    import brf_pkg::*;

    localparam int QDEPTH = 2;

    cmd_t       entry_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       dec;
    logic       push;

    always_comb
    begin
        dec.wbyte  = s_tdata[BYTE_W-1:0];
        dec.length = s_tdata[BYTE_W+LEN_W-1:BYTE_W];
        unique case (s_tuser)
            CMD_WRITE:     dec.op = OP_WRITE;
            CMD_READ:      dec.op = OP_READ;
            CMD_CONSUME:   dec.op = OP_CONSUME;
            CMD_RST_READ:  dec.op = OP_RST_RD;
            CMD_RST_WRITE: dec.op = OP_RST_WR;
            default:       dec.op = OP_NOP;
        endcase
    end

    assign s_tready  = (fill_reg != 2'(QDEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: design/brf_back.sv
// ----------------------------------------------------------------------------
// brf_back
// Command execution: pointers, occupancy, byte store and the result register.
// ----------------------------------------------------------------------------
module brf_back #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [brf_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                      cmd_valid,
    input  brf_pkg::cmd_t             cmd,
    output logic                      cmd_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);

    import brf_pkg::*;

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int BW   = $clog2(MAX_BURST + 1);
    localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cap_reg, cap_next;
    logic [PW-1:0]     rp_reg, rp_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [BW-1:0]     remain_reg, remain_next;
    logic [BW-1:0]     burst_n_reg, burst_n_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_flag_reg, out_flag_next;
    logic [LEN_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;
    logic [LEN_W-1:0]  out_occ_reg, out_occ_next;

    logic              out_free;
    logic [CMPW-1:0]   len_ext, cnt_ext, avail, cfg_ext, cfg_clamp;
    logic [CMPW-1:0]   rd_cmp;
    logic [BW-1:0]     rd_n;
    logic [CW-1:0]     cons_n;
    logic [CW-1:0]     rp_plus, wp_plus;
    logic [PW-1:0]     rp_inc, wp_inc, cons_ptr;
    logic [CW:0]       cons_sum;

    logic              ram_we, ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    assign out_free = !out_valid_reg || m_tready;

    // request sizes
    assign len_ext = CMPW'(cmd.length);
    assign cnt_ext = CMPW'(cnt_reg);
    assign avail   = (len_ext < cnt_ext) ? len_ext : cnt_ext;
    assign rd_cmp  = (avail > CMPW'(MAX_BURST)) ? CMPW'(MAX_BURST) : avail;
    assign rd_n    = BW'(rd_cmp);
    assign cons_n  = CW'(avail);

    // pointer wrap at capacity
    assign rp_plus  = CW'(rp_reg) + CW'(1);
    assign wp_plus  = CW'(wp_reg) + CW'(1);
    assign rp_inc   = (rp_plus == cap_reg) ? '0 : PW'(rp_plus);
    assign wp_inc   = (wp_plus == cap_reg) ? '0 : PW'(wp_plus);
    assign cons_sum = (CW+1)'(rp_reg) + (CW+1)'(cons_n);
    assign cons_ptr = (cons_sum >= (CW+1)'(cap_reg)) ?
                      PW'(cons_sum - (CW+1)'(cap_reg)) : PW'(cons_sum);

    // clamp capacity into 1..DEPTH
    assign cfg_ext   = CMPW'(cfg_wdata);
    assign cfg_clamp = (cfg_ext == '0) ? CMPW'(1) :
                       (cfg_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cfg_ext;

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (cmd.wbyte),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.op == OP_READ && rd_n != '0)
                begin
                    state_next = ST_BURST;
                end
            end
            ST_BURST:
            begin
                if (out_free && remain_reg == BW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cap_next       = cap_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        remain_next    = remain_reg;
        burst_n_next   = burst_n_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_flag_next  = out_flag_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_occ_next   = out_occ_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.op == OP_READ && rd_n != '0)
                begin
                    // take the whole burst off the count now; occupancy is final
                    cmd_pop      = 1'b1;
                    cnt_next     = cnt_reg - CW'(rd_n);
                    remain_next  = rd_n;
                    burst_n_next = rd_n;
                    ram_re       = 1'b1;
                    rp_next      = rp_inc;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_flag_next  = 1'b0;
                    out_cnt_next   = '0;
                    out_last_next  = 1'b1;
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            if (cnt_reg < cap_reg)
                            begin
                                ram_we       = 1'b1;
                                wp_next      = wp_inc;
                                cnt_next     = cnt_reg + CW'(1);
                                out_cnt_next = LEN_W'(1);
                            end
                        end
                        OP_CONSUME:
                        begin
                            rp_next      = cons_ptr;
                            cnt_next     = cnt_reg - cons_n;
                            out_cnt_next = LEN_W'(cons_n);
                        end
                        OP_RST_RD:
                        begin
                            rp_next  = wp_reg;
                            cnt_next = '0;
                        end
                        OP_RST_WR:
                        begin
                            wp_next  = rp_reg;
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_occ_next = LEN_W'(cnt_next);
                end
            end
            ST_BURST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_flag_next  = 1'b1;
                    out_cnt_next   = LEN_W'(burst_n_reg);
                    out_last_next  = (remain_reg == BW'(1));
                    out_occ_next   = LEN_W'(cnt_reg);
                    remain_next    = remain_reg - BW'(1);
                    if (remain_reg != BW'(1))
                    begin
                        // fetch the next byte while this one goes out
                        ram_re  = 1'b1;
                        rp_next = rp_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            cap_next = CW'(cfg_clamp);
            rp_next  = '0;
            wp_next  = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg   <= remain_next;
        burst_n_reg  <= burst_n_next;
        out_byte_reg <= out_byte_next;
        out_flag_reg <= out_flag_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
        out_occ_reg  <= out_occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CW'(DEPTH);
            rp_reg        <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_occ_reg, out_cnt_reg, out_byte_reg};
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: design/brf_chk.sv
// ----------------------------------------------------------------------------
// brf_chk
// Port-level checks on the result stream of the circular byte FIFO.
// ----------------------------------------------------------------------------
module brf_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // a beat without a byte is always the only beat of its command
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("byteless result not marked last");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("byteless result carries a nonzero byte");

    a_burst_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[18:8] != 11'd0)
        else $error("delivered byte with zero count");

endmodule

bind byte_ring_fifo_top brf_chk u_brf_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
